// ===== src/hqpe_pkg.sv =====
package hqpe_pkg;

	localparam int unsigned LINE_CAPACITY  = 128;
	localparam int unsigned QUERY_CAPACITY = 32;
	localparam int unsigned IDX_W          = $clog2(LINE_CAPACITY);

	localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(LINE_CAPACITY - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	typedef enum logic [2:0] {
		KIND_KEY      = 3'd0,
		KIND_VALUE    = 3'd1,
		KIND_PAIR_END = 3'd2,
		KIND_DONE     = 3'd3,
		KIND_TOO_LONG = 3'd4,
		KIND_BLANK    = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BLANK,
		S_TOO_LONG,
		S_TOK_BEGIN,
		S_SCAN,
		S_SCAN_CHK,
		S_TOK_END,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_PAIR_END,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic  store;
		logic  clear_line;
		logic  tok_init;
		logic  scan_init;
		logic  rd_p;
		logic  scan_step;
		logic  set_end;
		logic  emit_init;
		logic  rd_k;
		logic  k_inc;
		logic  tok_next;
		logic  out_load;
		kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic in_is_cr;
		logic in_is_lf;
		logic len_zero;
		logic line_ok;
		logic too_long;
		logic tok_at_sp;
		logic p_at_sp;
		logic rd_is_amp;
		logic eq_found;
		logic k_at_end;
		logic k_at_eq;
		logic k_before_eq;
		logic slot_free;
	} sts_t;

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h47;
			2'd1: c = 8'h45;
			2'd2: c = 8'h54;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

endpackage

// ===== src/hqpe_byte_if.sv =====
interface hqpe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/hqpe_result_if.sv =====
interface hqpe_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output kind, output data_byte, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input last, output ready);
endinterface

// ===== src/hqpe_ctrl.sv =====
module hqpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  hqpe_pkg::sts_t sts,
	output hqpe_pkg::cmd_t cmd,
	output logic          in_ready
);
	import hqpe_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && sts.in_is_lf) begin
					if (sts.len_zero) begin
						state_d = S_BLANK;
					end else if (!sts.line_ok) begin
						state_d = S_IDLE;
					end else if (sts.too_long) begin
						state_d = S_TOO_LONG;
					end else begin
						state_d = S_TOK_BEGIN;
					end
				end
			end
			S_BLANK, S_TOO_LONG, S_DONE: begin
				if (sts.slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_TOK_BEGIN: begin
				state_d = sts.tok_at_sp ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				state_d = sts.p_at_sp ? S_TOK_END : S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = sts.rd_is_amp ? S_TOK_END : S_SCAN;
			end
			S_TOK_END: begin
				state_d = sts.eq_found ? S_EMIT_RD : S_TOK_BEGIN;
			end
			S_EMIT_RD: begin
				state_d = sts.k_at_end ? S_PAIR_END : S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (sts.k_at_eq || sts.slot_free) begin
					state_d = S_EMIT_RD;
				end
			end
			S_PAIR_END: begin
				if (sts.slot_free) begin
					state_d = S_TOK_BEGIN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.out_kind = KIND_KEY;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = !sts.in_is_cr && !sts.in_is_lf;
					if (sts.in_is_lf && !sts.len_zero) begin
						cmd.clear_line = 1'b1;
						cmd.tok_init   = 1'b1;
					end
				end
			end
			S_BLANK: begin
				cmd.out_load = sts.slot_free;
				cmd.out_kind = KIND_BLANK;
			end
			S_TOO_LONG: begin
				cmd.out_load = sts.slot_free;
				cmd.out_kind = KIND_TOO_LONG;
			end
			S_DONE: begin
				cmd.out_load = sts.slot_free;
				cmd.out_kind = KIND_DONE;
			end
			S_TOK_BEGIN: begin
				cmd.scan_init = !sts.tok_at_sp;
			end
			S_SCAN: begin
				cmd.set_end = sts.p_at_sp;
				cmd.rd_p    = !sts.p_at_sp;
			end
			S_SCAN_CHK: begin
				cmd.set_end   = sts.rd_is_amp;
				cmd.scan_step = !sts.rd_is_amp;
			end
			S_TOK_END: begin
				cmd.emit_init = sts.eq_found;
				cmd.tok_next  = !sts.eq_found;
			end
			S_EMIT_RD: begin
				cmd.rd_k = !sts.k_at_end;
			end
			S_EMIT_OUT: begin
				cmd.out_kind = sts.k_before_eq ? KIND_KEY : KIND_VALUE;
				if (sts.k_at_eq) begin
					cmd.k_inc = 1'b1;
				end else if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.k_inc    = 1'b1;
				end
			end
			S_PAIR_END: begin
				cmd.out_kind = KIND_PAIR_END;
				cmd.out_load = sts.slot_free;
				cmd.tok_next = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/hqpe_datapath.sv =====
module hqpe_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     in_byte,
	input  hqpe_pkg::cmd_t cmd,
	output hqpe_pkg::sts_t sts,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [2:0]     kind,
	output logic [7:0]     data_byte,
	output logic           last
);
	import hqpe_pkg::*;

	logic [7:0]       line_mem_q [LINE_CAPACITY];
	logic [7:0]       rd_q;
	logic [IDX_W-1:0] len_q;
	logic             nul_seen_q;
	logic             pfx_bad_q;
	logic             q_found_q;
	logic             sp_found_q;
	logic [IDX_W-1:0] q_pos_q;
	logic [IDX_W-1:0] sp_pos_q;
	logic [IDX_W-1:0] tok_q;
	logic [IDX_W-1:0] p_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] end_q;
	logic [IDX_W-1:0] eq_q;
	logic             eq_found_q;
	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       data_q;
	logic             last_q;

	logic             room;
	logic             do_store;
	logic [IDX_W-1:0] qlen;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	assign room     = len_q != MAX_LEN;
	assign do_store = cmd.store && room;
	assign qlen     = sp_pos_q - q_pos_q - IDX_W'(1);
	assign rd_en    = cmd.rd_p || cmd.rd_k;
	assign rd_addr  = cmd.rd_k ? k_q : p_q;

	always_ff @(posedge clk) begin
		if (do_store) begin
			line_mem_q[len_q] <= in_byte;
		end
		if (rd_en) begin
			rd_q <= line_mem_q[rd_addr];
		end
	end

	// line text tracking, updated as bytes are stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			nul_seen_q <= 1'b0;
			pfx_bad_q  <= 1'b0;
			q_found_q  <= 1'b0;
			sp_found_q <= 1'b0;
		end else if (cmd.clear_line) begin
			len_q      <= '0;
			nul_seen_q <= 1'b0;
			pfx_bad_q  <= 1'b0;
			q_found_q  <= 1'b0;
			sp_found_q <= 1'b0;
		end else if (do_store) begin
			len_q <= len_q + IDX_W'(1);
			if (!nul_seen_q) begin
				if (in_byte == CH_NUL) begin
					nul_seen_q <= 1'b1;
				end else begin
					if (len_q < IDX_W'(4) && in_byte != prefix_char(len_q[1:0])) begin
						pfx_bad_q <= 1'b1;
					end
					if (!q_found_q && len_q >= IDX_W'(4) && in_byte == CH_QMARK) begin
						q_found_q <= 1'b1;
					end else if (q_found_q && !sp_found_q && in_byte == CH_SPACE) begin
						sp_found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_store && !nul_seen_q && in_byte != CH_NUL) begin
			if (!q_found_q && len_q >= IDX_W'(4) && in_byte == CH_QMARK) begin
				q_pos_q <= len_q;
			end else if (q_found_q && !sp_found_q && in_byte == CH_SPACE) begin
				sp_pos_q <= len_q;
			end
		end
	end

	// token walk
	always_ff @(posedge clk) begin
		if (cmd.tok_init) begin
			tok_q <= q_pos_q + IDX_W'(1);
		end else if (cmd.tok_next) begin
			tok_q <= end_q + IDX_W'(end_q != sp_pos_q);
		end
		if (cmd.scan_init) begin
			p_q <= tok_q;
		end else if (cmd.scan_step) begin
			p_q <= p_q + IDX_W'(1);
		end
		if (cmd.set_end) begin
			end_q <= p_q;
		end
		if (cmd.scan_step && !eq_found_q && rd_q == CH_EQ) begin
			eq_q <= p_q;
		end
		if (cmd.emit_init) begin
			k_q <= tok_q;
		end else if (cmd.k_inc) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			eq_found_q <= 1'b0;
		end else if (cmd.scan_step && rd_q == CH_EQ) begin
			eq_found_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			data_q <= (cmd.out_kind == KIND_KEY || cmd.out_kind == KIND_VALUE) ? rd_q : 8'h00;
			last_q <= cmd.out_kind == KIND_DONE || cmd.out_kind == KIND_TOO_LONG ||
			          cmd.out_kind == KIND_BLANK;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = data_q;
	assign last      = last_q;

	always_comb begin
		sts.in_is_cr    = in_byte == CH_CR;
		sts.in_is_lf    = in_byte == CH_LF;
		sts.len_zero    = len_q == '0;
		sts.line_ok     = !pfx_bad_q && q_found_q && sp_found_q;
		sts.too_long    = 32'(qlen) >= 32'(QUERY_CAPACITY);
		sts.tok_at_sp   = tok_q == sp_pos_q;
		sts.p_at_sp     = p_q == sp_pos_q;
		sts.rd_is_amp   = rd_q == CH_AMP;
		sts.eq_found    = eq_found_q;
		sts.k_at_end    = k_q == end_q;
		sts.k_at_eq     = k_q == eq_q;
		sts.k_before_eq = k_q < eq_q;
		sts.slot_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== src/http_query_pair_extractor_core.sv =====
// channel  dir  payload                              transaction
// chars    in   in_byte[7:0]                         one line character
// pairs    out  kind[2:0], data_byte[7:0], last      one key/value byte or marker
//
// An ordinary byte or carriage return is accepted in the idle state; the line memory takes one write a cycle.
// A newline walks the stored query through the single memory read port: each query byte is read
// to find each token's end, then each key or value byte of a pair is read again to emit it.
// arst_n clears the line length, parse flags, controller and output valid; no memory clearing.
// A stall on pairs holds the walk; chars is not ready until the walk for a newline is done.
module http_query_pair_extractor_core (
	input  logic          clk,
	input  logic          arst_n,
	hqpe_byte_if.sink     chars,
	hqpe_result_if.source pairs
);
	import hqpe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hqpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (chars.ready)
	);

	hqpe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (chars.in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (pairs.ready),
		.out_valid (pairs.valid),
		.kind      (pairs.kind),
		.data_byte (pairs.data_byte),
		.last      (pairs.last)
	);

endmodule

// ===== tb/http_query_pair_extractor_core_test.sv =====
module http_query_pair_extractor_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hqpe_pkg::*;

	localparam logic [7:0] CH_G     = "G";
	localparam logic [7:0] CH_E     = "E";
	localparam logic [7:0] CH_T     = "T";
	localparam logic [7:0] CH_A     = "a";
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_SCORE = "_";
	localparam int unsigned RANDOM_CHARS = 45;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned SETTLE       = 300;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} pair_t;

	logic clk;
	logic arst_n;

	hqpe_byte_if   chars_if ();
	hqpe_result_if pairs_if ();

	http_query_pair_extractor_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.pairs  (pairs_if)
	);

	logic [7:0] pending_chars[$];
	pair_t      expected_pairs[$];
	logic [7:0] line_buf[LINE_CAPACITY];
	int         line_len;
	int         faults;
	int         pairs_seen;
	logic       chars_fire;
	logic       calm;
	int         send_gap;
	logic       send_quiet;
	int         recv_gap;
	logic       recv_quiet;
	int         hold_left;
	logic       hold_done;

	function automatic void push_pair(kind_t k, logic [7:0] d);
		pair_t p;
		p.kind = k;
		p.data = d;
		p.last = 1'b0;
		expected_pairs.push_back(p);
	endfunction

	function automatic int seek(int from, int upto, logic [7:0] ch);
		for (int i = from; i < upto; i++) begin
			if (line_buf[i] == ch) begin
				return i;
			end
		end
		return upto;
	endfunction

	function automatic void parse_char(logic [7:0] b);
		int before_n, text_len, q, sp, i, stop, eq;
		before_n = expected_pairs.size();
		if (b == CH_CR) begin
			return;
		end
		if (b != CH_LF) begin
			if (line_len < int'(LINE_CAPACITY) - 1) begin
				line_buf[line_len] = b;
				line_len++;
			end
			return;
		end
		if (line_len == 0) begin
			push_pair(KIND_BLANK, 8'h00);
		end else begin
			text_len = seek(0, line_len, CH_NUL);
			line_len = 0;
			q = text_len;
			sp = text_len;
			if (text_len >= 4 && line_buf[0] == CH_G && line_buf[1] == CH_E &&
				line_buf[2] == CH_T && line_buf[3] == CH_SPACE) begin
				q = seek(4, text_len, CH_QMARK);
			end
			if (q < text_len) begin
				sp = seek(q + 1, text_len, CH_SPACE);
			end
			if (sp < text_len) begin
				if (sp - q - 1 >= int'(QUERY_CAPACITY)) begin
					push_pair(KIND_TOO_LONG, 8'h00);
				end else begin
					i = q + 1;
					while (i < sp) begin
						if (line_buf[i] == CH_AMP) begin
							i++;
						end else begin
							stop = seek(i, sp, CH_AMP);
							eq = seek(i, stop, CH_EQ);
							if (eq < stop) begin
								for (int k = i; k < eq; k++) begin
									push_pair(KIND_KEY, line_buf[k]);
								end
								for (int k = eq + 1; k < stop; k++) begin
									push_pair(KIND_VALUE, line_buf[k]);
								end
								push_pair(KIND_PAIR_END, 8'h00);
							end
							i = stop;
						end
					end
					push_pair(KIND_DONE, 8'h00);
				end
			end
		end
		if (expected_pairs.size() > before_n) begin
			expected_pairs[expected_pairs.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			pending_chars.push_back(s[i]);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("http_query_pair_extractor_core_test NOT OK");
		$finish;
	end

	// sender: offer the next character once the previous transaction is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
		end else if (!chars_if.valid || chars_fire) begin
			if (!send_quiet && !calm && send_gap == 0 && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(1, 4);
			end
			if (send_gap > 0) begin
				send_gap--;
				chars_if.valid <= 1'b0;
			end else if (pending_chars.size() != 0) begin
				chars_if.in_byte <= pending_chars.pop_front();
				chars_if.valid <= 1'b1;
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
		if ($urandom_range(0, 49) == 0) begin
			send_quiet = !send_quiet;
		end
	end

	// receiver: random stalls, plus one long hold to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			pairs_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pairs_if.ready <= 1'b0;
		end else if (!hold_done && pairs_seen >= 20) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			pairs_if.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			pairs_if.ready <= 1'b0;
		end else begin
			pairs_if.ready <= 1'b1;
			if (!recv_quiet && !calm && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(1, 4);
			end
		end
		if ($urandom_range(0, 49) == 0) begin
			recv_quiet = !recv_quiet;
		end
	end

	always @(posedge clk) begin
		pair_t want;
		chars_fire <= arst_n && chars_if.valid && chars_if.ready;
		if (arst_n && chars_if.valid && chars_if.ready) begin
			parse_char(chars_if.in_byte);
		end
		if (arst_n && pairs_if.valid && pairs_if.ready) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t pairs: expected nothing, got kind %0d data %02h last %0b",
					$time, pairs_if.kind, pairs_if.data_byte, pairs_if.last);
				faults++;
			end else begin
				want = expected_pairs.pop_front();
				if (pairs_if.kind !== want.kind || pairs_if.data_byte !== want.data ||
					pairs_if.last !== want.last) begin
					$display("%0t pairs: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
						$time, want.kind, want.data, want.last,
						pairs_if.kind, pairs_if.data_byte, pairs_if.last);
					faults++;
				end
			end
			pairs_seen++;
		end
	end

	initial begin
		logic [7:0] line_q[$];
		string      tail;
		int         r, n, qpos, sppos, total, cut;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.in_byte = 8'h00;
		pairs_if.ready = 1'b0;
		chars_fire = 1'b0;
		calm = 1'b0;
		send_gap = 0;
		send_quiet = 1'b0;
		recv_gap = 0;
		recv_quiet = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		faults = 0;
		pairs_seen = 0;
		line_len = 0;
		tail = "HTTP/1.1";

		add_text("\n");
		add_text("\r\n");
		add_text("GET /x?&a=b&&=c&d=&e&f==g& HTTP/1.1\r\n");
		add_text("GE\n");
		add_text("PUT ?a=b \n");
		add_text("GET /a=b \n");
		add_text("GET ?a=b\n");
		add_text("GET ?a");
		pending_chars.push_back(CH_NUL);
		add_text("=b \n");
		add_text("GET ?");
		pending_chars.push_back(8'hFF);
		pending_chars.push_back(CH_EQ);
		pending_chars.push_back(8'h80);
		add_text(" \n");
		add_text("GET ?abcdefghijklmnopqrstuvwxyz=1234 \n");
		add_text("GET ?abcdefghijklmnopqrstuvwxyz=12345 \n");
		add_text("GET ?");
		repeat (130) pending_chars.push_back(CH_A);
		add_text(" \n");
		add_text("GET ?z=1 \n");

		total = 0;
		while (total < RANDOM_CHARS) begin
			r = $urandom_range(0, 99);
			line_q = {};
			if (r < 85) begin
				line_q = {CH_G, CH_E, CH_T, CH_SPACE};
				n = $urandom_range(0, 3);
				repeat (n) line_q.push_back(8'($urandom_range(97, 122)));
				qpos = line_q.size();
				line_q.push_back(CH_QMARK);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 14);
				repeat (n) begin
					case ($urandom_range(0, 9))
						0, 1, 2: line_q.push_back(CH_AMP);
						3, 4: line_q.push_back(CH_EQ);
						9: line_q.push_back(8'($urandom_range(33, 255)));
						default: line_q.push_back(8'($urandom_range(97, 100)));
					endcase
				end
				sppos = line_q.size();
				line_q.push_back(CH_SPACE);
				if ($urandom_range(0, 1) == 1) begin
					for (int i = 0; i < tail.len(); i++) begin
						line_q.push_back(tail[i]);
					end
				end
				if (r >= 70) begin
					case ($urandom_range(0, 4))
						0: line_q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
						1: line_q[qpos] = CH_SLASH;
						2: line_q[sppos] = CH_SCORE;
						3: line_q[$urandom_range(0, line_q.size() - 1)] = CH_NUL;
						default: begin
							cut = $urandom_range(1, line_q.size() - 1);
							while (line_q.size() > cut) void'(line_q.pop_back());
						end
					endcase
				end
			end else if (r < 95) begin
				n = $urandom_range(1, 12);
				repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 2) == 0) begin
				line_q.push_back(CH_CR);
			end
			line_q.push_back(CH_LF);
			foreach (line_q[i]) begin
				pending_chars.push_back(line_q[i]);
				if (line_q[i] != CH_CR) begin
					total++;
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() > 60) @(posedge clk);
		calm = 1'b1;
		while (pending_chars.size() != 0 || chars_if.valid) @(posedge clk);
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (faults == 0) begin
			$display("http_query_pair_extractor_core_test OK");
		end else begin
			$display("http_query_pair_extractor_core_test NOT OK");
		end
		$finish;
	end

endmodule
